// File: sv/erd_pkg.sv
package erd_pkg;

  // Output lanes per result and width of the decoded-length counter
  localparam int unsigned LANES       = 8;
  localparam int unsigned LENGTH_BITS = 16;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OUT_W    = 64;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned OFFSET_W = 3;
  // count byte plus offset: up to 255 + 7
  localparam int unsigned RUN_W    = 9;
  localparam int unsigned ROOM_W   = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;

  // Command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // APB register indexes
  localparam logic [1:0] REG_ESCAPE   = 2'd0;
  localparam logic [1:0] REG_SINGLE   = 2'd1;
  localparam logic [1:0] REG_OFFSET   = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0]   escape_value;
    logic [DATA_W-1:0]   single_marker;
    logic [OFFSET_W-1:0] run_offset;
    logic [CAP_W-1:0]    capacity;
  } cfg_t;

  // One decoded item: value repeated run times, plus packet-close status
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic [RUN_W-1:0]   run;
    logic               eop;
    logic               ok;
    logic [TOTAL_W-1:0] total;
  } cmd_t;

endpackage

// File: sv/escaped_rle_decoder_core.sv
// Escape-based run-length decoder. Source bytes enter one per transaction on the push/full
// side; decoded bytes leave on the pop/empty side in results of up to eight equal lanes. The
// front stage parses each byte (literal, escape, count and value bytes alike) and hands a
// run command to a two-entry command queue; the back stage, if popped, sends a run of length
// L as ceil(L/8) results, one per cycle, and a literal as one result. A stream of literals
// goes at one byte per cycle; input stalls only while the command queue is full, i.e. while
// the back stage is still expanding earlier runs or the result side is not popping. The
// closing status (done_res, ok, total_length) rides on the last result of the end-of-packet
// byte, or on a status-only result with byte_count 0. Registers (APB, byte address 4*i):
// escape_value, single_marker, run_offset, capacity; write them only while the block is idle.
module escaped_rle_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [erd_pkg::DATA_W-1:0]    data_byte_i,
  input  logic                          end_of_packet_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [erd_pkg::OUT_W-1:0]     out_bytes_o,
  output logic [erd_pkg::CNT_W-1:0]     byte_count_o,
  output logic                          last_o,
  output logic                          done_res_o,
  output logic                          ok_o,
  output logic [erd_pkg::TOTAL_W-1:0]   total_length_o
);

  erd_pkg::cfg_t cfg;
  erd_pkg::cmd_t front_cmd, head_cmd;
  logic          cmd_push, cmd_full, cmd_valid, cmd_pop;

  erd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  erd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .push_i          (push),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .cmd_full_i      (cmd_full),
    .full_o          (full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (front_cmd)
  );

  erd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  erd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (head_cmd),
    .cmd_pop_o      (cmd_pop),
    .pop            (pop),
    .empty          (empty),
    .out_bytes_o    (out_bytes_o),
    .byte_count_o   (byte_count_o),
    .last_o         (last_o),
    .done_res_o     (done_res_o),
    .ok_o           (ok_o),
    .total_length_o (total_length_o)
  );

endmodule

// File: sv/erd_cfg.sv
module erd_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output erd_pkg::cfg_t      cfg_o
);

  erd_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        erd_pkg::REG_ESCAPE:   cfg_d.escape_value  = pwdata[erd_pkg::DATA_W-1:0];
        erd_pkg::REG_SINGLE:   cfg_d.single_marker = pwdata[erd_pkg::DATA_W-1:0];
        erd_pkg::REG_OFFSET:   cfg_d.run_offset    = pwdata[erd_pkg::OFFSET_W-1:0];
        erd_pkg::REG_CAPACITY: cfg_d.capacity      = pwdata[erd_pkg::CAP_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      erd_pkg::REG_ESCAPE:   prdata = 32'(cfg_q.escape_value);
      erd_pkg::REG_SINGLE:   prdata = 32'(cfg_q.single_marker);
      erd_pkg::REG_OFFSET:   prdata = 32'(cfg_q.run_offset);
      erd_pkg::REG_CAPACITY: prdata = 32'(cfg_q.capacity);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_value  <= 8'd255;
      cfg_q.single_marker <= 8'd0;
      cfg_q.run_offset    <= 3'd2;
      cfg_q.capacity      <= 16'hFFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/erd_front.sv
module erd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  erd_pkg::cfg_t               cfg_i,
  input  logic                        push_i,
  input  logic [erd_pkg::DATA_W-1:0]  data_byte_i,
  input  logic                        end_of_packet_i,
  input  logic                        cmd_full_i,
  output logic                        full_o,
  output logic                        cmd_push_o,
  output erd_pkg::cmd_t               cmd_o
);

  localparam logic [1:0] PH_LITERAL = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_VALUE   = 2'd2;

  logic [1:0]                       phase_q, phase_d;
  logic [erd_pkg::DATA_W-1:0]       held_q, held_d;
  logic [erd_pkg::LENGTH_BITS-1:0]  written_q, written_d;
  logic                             failed_q, failed_d;

  logic                             accept;
  logic [erd_pkg::ROOM_W-1:0]       written_ext, cap_ext, room;
  logic [erd_pkg::RUN_W-1:0]        run_len;
  logic                             good;

  assign full_o      = cmd_full_i;
  assign accept      = push_i && !cmd_full_i;
  assign written_ext = erd_pkg::ROOM_W'(written_q);
  assign cap_ext     = erd_pkg::ROOM_W'(cfg_i.capacity);
  assign room        = (written_ext < cap_ext) ? (cap_ext - written_ext) : '0;
  assign run_len     = (held_q == cfg_i.single_marker) ? erd_pkg::RUN_W'(1)
                     : erd_pkg::RUN_W'(held_q) + erd_pkg::RUN_W'(cfg_i.run_offset);

  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    written_d = written_q;
    failed_d  = failed_q;
    cmd_o       = '0;
    cmd_o.value = data_byte_i;

    if (!failed_q) begin
      unique case (phase_q)
        PH_COUNT: begin
          held_d  = data_byte_i;
          phase_d = PH_VALUE;
        end
        PH_VALUE: begin
          phase_d = PH_LITERAL;
          if (room < erd_pkg::ROOM_W'(run_len)) begin
            failed_d = 1'b1;
          end else begin
            cmd_o.run = run_len;
            written_d = written_q + erd_pkg::LENGTH_BITS'(run_len);
          end
        end
        default: begin
          // literal phase; the spare code behaves the same
          phase_d = PH_LITERAL;
          if (data_byte_i == cfg_i.escape_value) begin
            phase_d = PH_COUNT;
          end else if (room == '0) begin
            failed_d = 1'b1;
          end else begin
            cmd_o.run = erd_pkg::RUN_W'(1);
            written_d = written_q + erd_pkg::LENGTH_BITS'(1);
          end
        end
      endcase
    end

    good        = !failed_d && (phase_d == PH_LITERAL);
    cmd_o.eop   = end_of_packet_i;
    cmd_o.ok    = end_of_packet_i && good;
    cmd_o.total = (end_of_packet_i && good) ? erd_pkg::TOTAL_W'(written_d) : '0;

    if (end_of_packet_i) begin
      phase_d   = PH_LITERAL;
      held_d    = '0;
      written_d = '0;
      failed_d  = 1'b0;
    end
  end

  assign cmd_push_o = accept && ((cmd_o.run != '0) || end_of_packet_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LITERAL;
      held_q    <= '0;
      written_q <= '0;
      failed_q  <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      written_q <= written_d;
      failed_q  <= failed_d;
    end
  end

endmodule

// File: sv/erd_cmd_fifo.sv
module erd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  erd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output erd_pkg::cmd_t cmd_o
);

  erd_pkg::cmd_t                   mem_q [erd_pkg::CMD_DEPTH];
  logic [erd_pkg::CMD_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [erd_pkg::CMD_CNT_W-1:0]   count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == erd_pkg::CMD_CNT_W'(erd_pkg::CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [erd_pkg::CMD_PTR_W-1:0] ptr_inc(
    input logic [erd_pkg::CMD_PTR_W-1:0] p
  );
    return (p == erd_pkg::CMD_PTR_W'(erd_pkg::CMD_DEPTH - 1)) ? '0
         : p + erd_pkg::CMD_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + erd_pkg::CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - erd_pkg::CMD_CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/erd_back.sv
module erd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  erd_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [erd_pkg::OUT_W-1:0]    out_bytes_o,
  output logic [erd_pkg::CNT_W-1:0]    byte_count_o,
  output logic                         last_o,
  output logic                         done_res_o,
  output logic                         ok_o,
  output logic [erd_pkg::TOTAL_W-1:0]  total_length_o
);

  localparam logic [erd_pkg::RUN_W-1:0] LanesRun = erd_pkg::RUN_W'(erd_pkg::LANES);

  // remaining length of a run already partly sent
  logic                          started_q;
  logic [erd_pkg::RUN_W-1:0]     rem_q;

  logic                          out_valid_q;
  logic [erd_pkg::OUT_W-1:0]     out_bytes_q;
  logic [erd_pkg::CNT_W-1:0]     byte_count_q;
  logic                          last_q, done_q, ok_q;
  logic [erd_pkg::TOTAL_W-1:0]   total_q;

  logic [erd_pkg::RUN_W-1:0]     rem_sel;
  logic                          final_beat;
  logic                          fire;
  logic [erd_pkg::CNT_W-1:0]     beat_cnt;
  logic [erd_pkg::OUT_W-1:0]     beat_bytes;

  assign rem_sel    = started_q ? rem_q : cmd_i.run;
  assign final_beat = (rem_sel <= LanesRun);
  assign fire       = cmd_valid_i && (!out_valid_q || pop);
  assign cmd_pop_o  = fire && final_beat;
  assign beat_cnt   = final_beat ? erd_pkg::CNT_W'(rem_sel) : erd_pkg::CNT_W'(erd_pkg::LANES);

  always_comb begin
    beat_bytes = '0;
    for (int i = 0; i < erd_pkg::LANES; i++) begin
      if (erd_pkg::CNT_W'(i) < beat_cnt) begin
        beat_bytes[i*erd_pkg::DATA_W +: erd_pkg::DATA_W] = cmd_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        started_q   <= !final_beat;
        rem_q       <= rem_sel - LanesRun;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_bytes_q  <= beat_bytes;
      byte_count_q <= beat_cnt;
      last_q       <= final_beat;
      done_q       <= final_beat && cmd_i.eop;
      ok_q         <= final_beat && cmd_i.ok;
      total_q      <= final_beat ? cmd_i.total : '0;
    end
  end

  assign empty          = !out_valid_q;
  assign out_bytes_o    = out_bytes_q;
  assign byte_count_o   = byte_count_q;
  assign last_o         = last_q;
  assign done_res_o     = done_q;
  assign ok_o           = ok_q;
  assign total_length_o = total_q;

endmodule

// File: verif/tb_escaped_rle_decoder_core.sv
`timescale 1ns / 100ps

module tb_escaped_rle_decoder_core;

  localparam int unsigned DRAIN_TAIL = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {ST_LITERAL, ST_COUNT, ST_VALUE} dec_state_e;
  typedef enum logic [1:0] {ROW_DATA, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [erd_pkg::OUT_W-1:0]   bytes;
    logic [erd_pkg::CNT_W-1:0]   cnt;
    logic                        last;
    logic                        done;
    logic                        ok;
    logic [erd_pkg::TOTAL_W-1:0] total;
  } beat_t;

  // CFG rows: reg_idx/val is a register write; DATA rows: val[7:0] is the source byte
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [15:0] val;
    logic        eop;
    logic        typed;
    beat_t       res;
  } row_t;

  localparam beat_t NO_BEAT    = '0;
  localparam beat_t FAIL_CLOSE = '{64'd0, 4'd0, 1'b1, 1'b1, 1'b0, 16'd0};

  localparam int unsigned NDIR = 32;
  localparam row_t DIRECTED [NDIR] = '{
    // reset settings: escape FF, single marker 00, offset 2, capacity FFFF
    '{ROW_DATA, 2'd0, 16'h0000, 1'b0, 1'b1, '{64'h00, 4'd1, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{ROW_DATA, 2'd0, 16'h00FE, 1'b1, 1'b1, '{64'hFE, 4'd1, 1'b1, 1'b1, 1'b1, 16'd2}},
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b1, 1'b1, FAIL_CLOSE},          // close inside escape
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0006, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h005A, 1'b0, 1'b1,
      '{64'h5A5A5A5A5A5A5A5A, 4'd8, 1'b1, 1'b0, 1'b0, 16'd0}},     // run of exactly 8
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0081, 1'b1, 1'b0, NO_BEAT},             // 257 bytes, 33 beats
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0003, 1'b1, 1'b1, FAIL_CLOSE},          // close with count pending
    '{ROW_CFG, erd_pkg::REG_CAPACITY, 16'h0000, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0041, 1'b1, 1'b1, FAIL_CLOSE},
    '{ROW_CFG, erd_pkg::REG_CAPACITY, 16'h0003, 1'b0, 1'b0, NO_BEAT},
    '{ROW_CFG, erd_pkg::REG_ESCAPE,   16'h0000, 1'b0, 1'b0, NO_BEAT},
    '{ROW_CFG, erd_pkg::REG_SINGLE,   16'h00FF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_CFG, erd_pkg::REG_OFFSET,   16'h0000, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0000, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h007E, 1'b0, 1'b1, '{64'h7E, 4'd1, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{ROW_DATA, 2'd0, 16'h0000, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0002, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0011, 1'b0, 1'b0, NO_BEAT},             // fills capacity exactly
    '{ROW_DATA, 2'd0, 16'h0055, 1'b1, 1'b1, FAIL_CLOSE},          // overflow
    '{ROW_DATA, 2'd0, 16'h00FF, 1'b0, 1'b1, '{64'hFF, 4'd1, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{ROW_CFG, erd_pkg::REG_CAPACITY, 16'h0000, 1'b0, 1'b0, NO_BEAT}, // below written
    '{ROW_DATA, 2'd0, 16'h0012, 1'b1, 1'b1, FAIL_CLOSE},
    '{ROW_CFG, erd_pkg::REG_CAPACITY, 16'hFFFF, 1'b0, 1'b0, NO_BEAT},
    '{ROW_CFG, erd_pkg::REG_OFFSET,   16'h0007, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h0000, 1'b0, 1'b0, NO_BEAT},
    '{ROW_DATA, 2'd0, 16'h00FE, 1'b0, 1'b0, NO_BEAT},             // 254 + 7 = 261 bytes
    '{ROW_DATA, 2'd0, 16'h0099, 1'b1, 1'b0, NO_BEAT}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [3:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          push;
  logic                          full;
  logic [erd_pkg::DATA_W-1:0]    data_byte_i;
  logic                          end_of_packet_i;
  logic                          empty;
  logic                          pop;
  logic [erd_pkg::OUT_W-1:0]     out_bytes_o;
  logic [erd_pkg::CNT_W-1:0]     byte_count_o;
  logic                          last_o;
  logic                          done_res_o;
  logic                          ok_o;
  logic [erd_pkg::TOTAL_W-1:0]   total_length_o;

  escaped_rle_decoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .empty          (empty),
    .pop            (pop),
    .out_bytes_o    (out_bytes_o),
    .byte_count_o   (byte_count_o),
    .last_o         (last_o),
    .done_res_o     (done_res_o),
    .ok_o           (ok_o),
    .total_length_o (total_length_o)
  );

  // decoder shadow: settings and packet state
  logic [erd_pkg::DATA_W-1:0]   esc_val;
  logic [erd_pkg::DATA_W-1:0]   single_val;
  logic [erd_pkg::OFFSET_W-1:0] offset_val;
  logic [erd_pkg::CAP_W-1:0]    cap_val;
  dec_state_e                   dec_state;
  logic [7:0]                   held_count;
  logic [erd_pkg::TOTAL_W-1:0]  written;
  logic                         failed;

  beat_t       expected_beats[$];
  logic        row_typed;
  beat_t       row_res;
  int unsigned tx_idle, rx_idle;
  int unsigned errors, bytes_sent, beats_checked, packets_closed, cfg_writes;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #4_000_000;
    $display("** escaped_rle_decoder_core: FAILED **");
    $finish;
  end

  function automatic beat_t data_beat(logic [7:0] v, int unsigned n);
    beat_t r;
    r = '0;
    for (int unsigned i = 0; i < n; i++) r.bytes[8*i +: 8] = v;
    r.cnt = erd_pkg::CNT_W'(n);
    return r;
  endfunction

  // Works out the beats one accepted source byte causes and queues them (or the typed result)
  task automatic decode_byte(input logic [7:0] b, input logic eop,
                             input logic typed, input beat_t typed_res);
    beat_t       beats[$];
    beat_t       tmp;
    int unsigned room, run, c;
    logic        good;
    room = (written < cap_val) ? int'(cap_val) - int'(written) : 0;
    if (!failed) begin
      case (dec_state)
        ST_COUNT: begin
          held_count = b;
          dec_state  = ST_VALUE;
        end
        ST_VALUE: begin
          run = (held_count == single_val) ? 1 : int'(held_count) + int'(offset_val);
          dec_state = ST_LITERAL;
          if (room < run) begin
            failed = 1'b1;
          end else begin
            while (run > 0) begin
              c = (run < erd_pkg::LANES) ? run : erd_pkg::LANES;
              beats.push_back(data_beat(b, c));
              run -= c;
              written += erd_pkg::TOTAL_W'(c);
            end
          end
        end
        default: begin
          dec_state = ST_LITERAL;
          if (b == esc_val) dec_state = ST_COUNT;
          else if (room == 0) failed = 1'b1;
          else begin
            beats.push_back(data_beat(b, 1));
            written += 1'b1;
          end
        end
      endcase
    end
    if (eop) begin
      good = !failed && dec_state == ST_LITERAL;
      if (beats.size() == 0) beats.push_back('0);
      tmp = beats.pop_back();
      tmp.done  = 1'b1;
      tmp.ok    = good;
      tmp.total = good ? written : '0;
      beats.push_back(tmp);
      dec_state  = ST_LITERAL;
      held_count = '0;
      written    = '0;
      failed     = 1'b0;
    end
    if (beats.size() > 0) begin
      tmp = beats.pop_back();
      tmp.last = 1'b1;
      beats.push_back(tmp);
    end
    if (typed) expected_beats.push_back(typed_res);
    else foreach (beats[i]) expected_beats.push_back(beats[i]);
  endtask

  // Input and output transactions, both sampled before this edge's updates
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni) begin
      if (push && !full) decode_byte(data_byte_i, end_of_packet_i, row_typed, row_res);
      if (pop && !empty) begin
        got = '{out_bytes_o, byte_count_o, last_o, done_res_o, ok_o, total_length_o};
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result bytes=%h cnt=%0d", $realtime, got.bytes, got.cnt);
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (want.done) packets_closed++;
          if (got.bytes !== want.bytes || got.cnt !== want.cnt || got.last !== want.last ||
              got.done !== want.done || got.ok !== want.ok || got.total !== want.total) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: mismatch exp bytes=%h cnt=%0d last=%0b done=%0b ok=%0b len=%0d",
                       $realtime, want.bytes, want.cnt, want.last, want.done, want.ok,
                       want.total);
              $display("          got bytes=%h cnt=%0d last=%0b done=%0b ok=%0b len=%0d",
                       got.bytes, got.cnt, got.last, got.done, got.ok, got.total);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) pop <= rst_ni && ($urandom_range(99) >= rx_idle);

  task automatic send_item(input logic [7:0] b, input logic eop,
                           input logic typed, input beat_t res);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    data_byte_i     <= b;
    end_of_packet_i <= eop;
    row_typed       <= typed;
    row_res         <= res;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // one edge first so the last accepted transaction is already predicted
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      erd_pkg::REG_ESCAPE: esc_val    = val[erd_pkg::DATA_W-1:0];
      erd_pkg::REG_SINGLE: single_val = val[erd_pkg::DATA_W-1:0];
      erd_pkg::REG_OFFSET: offset_val = val[erd_pkg::OFFSET_W-1:0];
      default:             cap_val    = val[erd_pkg::CAP_W-1:0];
    endcase
    cfg_writes++;
  endtask

  function automatic logic [7:0] pick_byte(int unsigned lo_pct, int unsigned hi_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < lo_pct) return 8'h00;
    if (r < hi_pct) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // One packet of well-formed tokens with random content, plus noise and cut-off escapes
  task automatic send_packet();
    logic [7:0]  pk[$];
    logic [7:0]  b;
    int unsigned ntok, r;
    ntok = $urandom_range(1, 6);
    for (int unsigned t = 0; t < ntok; t++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        do b = 8'($urandom_range(255)); while (b == esc_val);
        pk.push_back(b);
      end else if (r < 85) begin
        pk.push_back(esc_val);
        r = $urandom_range(99);
        if (r < 15) pk.push_back(single_val);
        else if (r < 90) pk.push_back(8'($urandom_range(12)));
        else pk.push_back(8'($urandom_range(255)));
        pk.push_back(8'($urandom_range(255)));
      end else if (r < 93) begin
        pk.push_back(esc_val);
        if ($urandom_range(1)) pk.push_back(8'($urandom_range(255)));
        break;
      end else begin
        pk.push_back(8'($urandom_range(255)));
      end
    end
    foreach (pk[i]) send_item(pk[i], i == pk.size() - 1, 1'b0, NO_BEAT);
  endtask

  initial begin
    int unsigned r, sub_start;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    push            = 1'b0;
    data_byte_i     = '0;
    end_of_packet_i = 1'b0;
    row_typed       = 1'b0;
    row_res         = '0;
    tx_idle         = 34;
    rx_idle         = 83;
    errors          = 0;
    bytes_sent      = 0;
    beats_checked   = 0;
    packets_closed  = 0;
    cfg_writes      = 0;
    esc_val         = 8'hFF;
    single_val      = 8'h00;
    offset_val      = 3'd2;
    cap_val         = 16'hFFFF;
    dec_state       = ST_LITERAL;
    held_count      = '0;
    written         = '0;
    failed          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < NDIR; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_drained();
        reg_write(DIRECTED[i].reg_idx, DIRECTED[i].val);
      end else begin
        send_item(DIRECTED[i].val[7:0], DIRECTED[i].eop, DIRECTED[i].typed,
                  DIRECTED[i].res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 34 : (ph == 1) ? 83 : 0;
      rx_idle = (ph == 0) ? 83 : (ph == 1) ? 34 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        wait_drained();
        reg_write(erd_pkg::REG_ESCAPE, {8'd0, pick_byte(25, 50)});
        reg_write(erd_pkg::REG_SINGLE, {8'd0, pick_byte(25, 50)});
        reg_write(erd_pkg::REG_OFFSET, 16'($urandom_range(7)));
        r = $urandom_range(99);
        if (r < 8) reg_write(erd_pkg::REG_CAPACITY, 16'd0);
        else if (r < 40) reg_write(erd_pkg::REG_CAPACITY, 16'($urandom_range(1, 40)));
        else if (r < 55) reg_write(erd_pkg::REG_CAPACITY, 16'($urandom_range(16'hFFFF)));
        else reg_write(erd_pkg::REG_CAPACITY, 16'hFFFF);
        sub_start = bytes_sent;
        while (bytes_sent - sub_start < 30) send_packet();
      end
    end

    wait_drained();
    $display("Sent %0d source bytes under %0d register writes;", bytes_sent, cfg_writes);
    $display("checked %0d results closing %0d packets.", beats_checked, packets_closed);
    if (errors == 0) begin
      $display("** escaped_rle_decoder_core: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** escaped_rle_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
